// ===== sv/pdlc_pkg.sv =====
package pdlc_pkg;

    // password length and derived widths
    localparam int PASS_LEN = 5;
    localparam int POS_W    = $clog2(PASS_LEN + 1);

    // item queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // port widths
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 8;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;
    localparam int SEQ_W     = 10;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_MAX_FAILURES  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_UNLOCK_TICKS  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_HOLD_TICKS    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_LOCK_TICKS    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_LOCKOUT_TICKS = 3'd4;

    // configuration reset values
    localparam logic [2:0] RST_MAX_FAILURES  = 3'd2;
    localparam logic [7:0] RST_UNLOCK_TICKS  = 8'd1;
    localparam logic [7:0] RST_HOLD_TICKS    = 8'd1;
    localparam logic [7:0] RST_LOCK_TICKS    = 8'd1;
    localparam logic [7:0] RST_LOCKOUT_TICKS = 8'd5;

    // link characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_YES   = 8'h79;
    localparam logic [7:0] CH_NO    = 8'h78;
    localparam logic [7:0] CH_MOTOR = 8'h6D;
    localparam logic [7:0] CH_CHG   = 8'h63;
    localparam logic [7:0] CH_UNMAT = 8'h75;

    // motor drive codes
    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_CW   = 2'd1;
    localparam logic [1:0] MOTOR_CCW  = 2'd2;

    // controller phase
    typedef enum logic [4:0] {
        PH_SETUP1  = 5'b00001,
        PH_SETUP2  = 5'b00010,
        PH_NORMAL  = 5'b00100,
        PH_DOOR    = 5'b01000,
        PH_LOCKOUT = 5'b10000
    } pdlc_phase_t;

    // classified input item
    typedef struct packed {
        logic       is_tick;
        logic       is_plus;
        logic       is_minus;
        logic [7:0] data;
    } pdlc_item_t;

endpackage

// ===== sv/pdlc_front.sv =====
module pdlc_front
    import pdlc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic                s_axis_tuser,
    output logic                item_valid,
    output pdlc_item_t          item,
    input  logic                item_ready
);

    logic       item_valid_reg;
    pdlc_item_t item_reg;
    pdlc_item_t item_next;

    // classify the incoming transaction
    always_comb begin
        item_next.is_tick  = s_axis_tuser;
        item_next.is_plus  = !s_axis_tuser && (s_axis_tdata == CH_PLUS);
        item_next.is_minus = !s_axis_tuser && (s_axis_tdata == CH_MINUS);
        item_next.data     = s_axis_tdata;
    end

    assign s_axis_tready = !item_valid_reg || item_ready;

    // one-entry input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            item_valid_reg <= 1'b1;
        end else if (item_ready) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/pdlc_fifo.sv =====
module pdlc_fifo
    import pdlc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  pdlc_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output pdlc_item_t pop_item
);

    pdlc_item_t entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + FIFO_CW'(1);
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - FIFO_CW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/pdlc_back.sv =====
module pdlc_back
    import pdlc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata,
    input  logic                item_valid,
    output logic                item_ready,
    input  pdlc_item_t          item,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tuser
);

    // configuration
    logic [2:0] max_fail_reg;
    logic [7:0] unlock_reg;
    logic [7:0] hold_reg;
    logic [7:0] lock_reg;
    logic [7:0] lockout_reg;

    // controller state
    pdlc_phase_t      phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             matched_reg, matched_next;
    logic [2:0]       fail_reg, fail_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [7:0]       first_reg [PASS_LEN];
    logic [7:0]       saved_reg [PASS_LEN];

    // output register
    logic                m_valid_reg;
    logic                m_user_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic             take;
    logic             first_we;
    logic             saved_copy;
    logic [7:0]       first_rd;
    logic [7:0]       saved_rd;
    logic             reply_valid;
    logic [7:0]       reply_byte;
    logic [1:0]       motor_mode;
    logic             buzz_level;
    logic             busy;
    logic [SEQ_W-1:0] seq_inc;
    logic [SEQ_W-1:0] t_unlock_end;
    logic [SEQ_W-1:0] t_hold_end;
    logic [SEQ_W-1:0] t_door_end;
    logic [SEQ_W-1:0] t_lockout_end;
    logic [3:0]       fail_inc;

    assign take       = item_valid && (!m_valid_reg || m_axis_tready);
    assign item_ready = !m_valid_reg || m_axis_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_fail_reg <= RST_MAX_FAILURES;
            unlock_reg   <= RST_UNLOCK_TICKS;
            hold_reg     <= RST_HOLD_TICKS;
            lock_reg     <= RST_LOCK_TICKS;
            lockout_reg  <= RST_LOCKOUT_TICKS;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MAX_FAILURES:  max_fail_reg <= cfg_wdata[2:0];
                CFG_UNLOCK_TICKS:  unlock_reg   <= cfg_wdata;
                CFG_HOLD_TICKS:    hold_reg     <= cfg_wdata;
                CFG_LOCK_TICKS:    lock_reg     <= cfg_wdata;
                CFG_LOCKOUT_TICKS: lockout_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // segment boundaries of the door sequence and lockout
    assign t_unlock_end  = SEQ_W'(1) + {2'b00, unlock_reg};
    assign t_hold_end    = t_unlock_end + {2'b00, hold_reg};
    assign t_door_end    = t_hold_end + {2'b00, lock_reg};
    assign t_lockout_end = SEQ_W'(1) + {2'b00, lockout_reg};
    assign seq_inc       = seq_reg + SEQ_W'(1);
    assign fail_inc      = {1'b0, fail_reg} + 4'd1;

    // stored password bytes at the current position
    always_comb begin
        first_rd = '0;
        saved_rd = '0;
        for (int i = 0; i < PASS_LEN; i++) begin
            if (pos_reg == POS_W'(i)) begin
                first_rd = first_reg[i];
                saved_rd = saved_reg[i];
            end
        end
    end

    // step the controller on one item
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        matched_next = matched_reg;
        fail_next    = fail_reg;
        seq_next     = seq_reg;
        first_we     = 1'b0;
        saved_copy   = 1'b0;
        reply_valid  = 1'b0;
        reply_byte   = '0;
        case (phase_reg)
            PH_DOOR, PH_LOCKOUT: begin
                if (item.is_tick) begin
                    if (seq_inc >= ((phase_reg == PH_DOOR) ? t_door_end : t_lockout_end)) begin
                        phase_next   = PH_NORMAL;
                        seq_next     = '0;
                        pos_next     = '0;
                        matched_next = 1'b1;
                    end else begin
                        seq_next = seq_inc;
                    end
                end
            end
            PH_SETUP1: begin
                if (!item.is_tick) begin
                    first_we = 1'b1;
                    if (pos_reg == POS_W'(PASS_LEN - 1)) begin
                        phase_next   = PH_SETUP2;
                        pos_next     = '0;
                        matched_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            PH_SETUP2: begin
                if (!item.is_tick) begin
                    if (pos_reg == POS_W'(PASS_LEN - 1)) begin
                        reply_valid = 1'b1;
                        if (matched_reg && (first_rd == item.data)) begin
                            reply_byte = CH_YES;
                            saved_copy = 1'b1;
                            phase_next = PH_NORMAL;
                        end else begin
                            reply_byte = CH_NO;
                            phase_next = PH_SETUP1;
                        end
                        pos_next     = '0;
                        matched_next = 1'b1;
                    end else begin
                        pos_next     = pos_reg + POS_W'(1);
                        matched_next = matched_reg && (first_rd == item.data);
                    end
                end
            end
            PH_NORMAL: begin
                if (!item.is_tick) begin
                    if (pos_reg < POS_W'(PASS_LEN)) begin
                        pos_next     = pos_reg + POS_W'(1);
                        matched_next = matched_reg && (saved_rd == item.data);
                    end else begin
                        // command byte after a full password
                        if (!matched_reg) begin
                            reply_valid = 1'b1;
                            reply_byte  = CH_UNMAT;
                            if (fail_inc > {1'b0, max_fail_reg}) begin
                                fail_next  = '0;
                                phase_next = PH_LOCKOUT;
                                seq_next   = '0;
                            end else begin
                                fail_next = fail_inc[2:0];
                            end
                        end else if (item.is_plus) begin
                            reply_valid = 1'b1;
                            reply_byte  = CH_MOTOR;
                            fail_next   = '0;
                            phase_next  = PH_DOOR;
                            seq_next    = '0;
                        end else if (item.is_minus) begin
                            reply_valid = 1'b1;
                            reply_byte  = CH_CHG;
                            fail_next   = '0;
                            phase_next  = PH_SETUP1;
                        end
                        pos_next     = '0;
                        matched_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // actuator levels after the step
    always_comb begin
        motor_mode = MOTOR_STOP;
        if (phase_next == PH_DOOR && seq_next != '0) begin
            if (seq_next < t_unlock_end) begin
                motor_mode = MOTOR_CW;
            end else if (seq_next < t_hold_end) begin
                motor_mode = MOTOR_STOP;
            end else if (seq_next < t_door_end) begin
                motor_mode = MOTOR_CCW;
            end
        end
        buzz_level = (phase_next == PH_LOCKOUT) && (seq_next != '0) &&
                     (seq_next < t_lockout_end);
        busy       = (phase_next == PH_DOOR) || (phase_next == PH_LOCKOUT);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SETUP1;
            pos_reg     <= '0;
            matched_reg <= 1'b1;
            fail_reg    <= '0;
            seq_reg     <= '0;
        end else if (take) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            matched_reg <= matched_next;
            fail_reg    <= fail_next;
            seq_reg     <= seq_next;
        end
    end

    // password storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < PASS_LEN; i++) begin
            if (take && first_we && pos_reg == POS_W'(i)) begin
                first_reg[i] <= item.data;
            end
            if (take && saved_copy) begin
                saved_reg[i] <= first_reg[i];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_user_reg <= reply_valid;
            m_data_reg <= {4'b0000, busy, buzz_level, motor_mode, reply_byte};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== sv/password_door_lock_controller.sv =====
// Password door lock controller.
// Input stream s_axis: one transaction per event. s_axis_tuser says what it is
// (0 a byte received on the link, 1 a one-second tick); s_axis_tdata holds the
// received byte, which ticks ignore.
// Output stream m_axis: exactly one transaction per input transaction, in order.
// m_axis_tuser is set when m_axis_tdata[7:0] carries a reply character to send
// on the link; the upper bits give motor drive, buzzer and busy after the event.
// Configuration: a write with cfg_we high stores cfg_wdata into the register
// selected by cfg_addr (0 max failures, 1 unlock, 2 hold, 3 lock, 4 lockout
// ticks); other indexes are ignored. Write only while the block is idle.
// Path: the input stage registers an accepted transaction, the item queue
// stores it, then the result register loads its result onto m_axis.
// Throughput: one transaction per cycle while m_axis_tready is high, set by
// the controller stepping one queued item per cycle.
// Reset (aresetn low, synchronous) empties the pipeline and puts the block into
// setup, waiting for the first copy of a new password; configuration returns to
// 2, 1, 1, 1, 5. When m_axis_tready is low the result register holds, the queue
// fills, and s_axis_tready drops once the queue and input stage are full.
module password_door_lock_controller
    import pdlc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tuser,   // [0] cmd
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [7:0] reply_byte, [9:8] motor_mode, [10] buzzer, [11] busy_res
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tuser    // [0] reply_valid
);

    logic       front_valid;
    logic       front_ready;
    pdlc_item_t front_item;
    logic       queue_valid;
    logic       queue_ready;
    pdlc_item_t queue_item;

    // accept and classify
    pdlc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (front_valid),
        .item          (front_item),
        .item_ready    (front_ready)
    );

    // decoupling queue
    pdlc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    // lock controller and result register
    pdlc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .item_valid    (queue_valid),
        .item_ready    (queue_ready),
        .item          (queue_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // a turning motor means the door sequence is running
    a_motor_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[9:8] != MOTOR_STOP) |-> m_axis_tdata[11])
        else $error("motor driven while not busy");

    // buzzer and motor never active together
    a_buzz_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[10] |->
            (m_axis_tdata[9:8] == MOTOR_STOP) && m_axis_tdata[11])
        else $error("buzzer sounding outside lockout");

    // no reply character without a reply flag
    a_reply_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("reply byte set without reply flag");

endmodule
